@@ hdl/bqlc_pkg.sv @@
// Package for the biquad low-pass cascade: widths, codes, control word types
// and the microcode store. No dependencies.
package bqlc_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int COEF_FRAC_BITS = 16;
  localparam int COEF_BITS      = COEF_FRAC_BITS + 2;
  localparam int SECTION_COUNT  = 2;
  localparam int SEC_BITS       = (SECTION_COUNT > 1) ? $clog2(SECTION_COUNT) : 1;
  localparam int PROD_BITS      = COEF_BITS + SAMPLE_BITS;
  localparam int ACC_BITS       = PROD_BITS + 3;
  localparam int PC_BITS        = 4;
  localparam int CFG_IDX_BITS   = 3;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;
  typedef logic [SEC_BITS-1:0]           sec_t;
  typedef logic [PC_BITS-1:0]            pc_t;

  // reset coefficients: Butterworth low-pass, 330 Hz at 8 kHz, Q2.16
  localparam coef_t B0_RESET = COEF_BITS'(927);
  localparam coef_t B1_RESET = COEF_BITS'(1853);
  localparam coef_t B2_RESET = COEF_BITS'(927);
  localparam coef_t A1_RESET = COEF_BITS'(-107256);
  localparam coef_t A2_RESET = COEF_BITS'(45428);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    COEF_B0, COEF_B1, COEF_B2, COEF_A1, COEF_A2
  } coef_sel_e;

  typedef enum logic [2:0] {
    OPND_X, OPND_XH0, OPND_XH1, OPND_YH0, OPND_YH1
  } opnd_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB
  } acc_op_e;

  typedef enum logic [2:0] {
    JMP_NEXT,      // fall through
    JMP_WAIT_IN,   // hold until a sample arrives
    JMP_MORE_SEC,  // to target while sections remain
    JMP_WAIT_OUT,  // hold until output register free, then to target
    JMP_ALWAYS
  } jump_e;

  typedef struct packed {
    coef_sel_e coef_sel;
    opnd_sel_e opnd_sel;
    acc_op_e   acc_op;
    logic      finish;  // round, saturate, shift histories
    logic      emit;    // load output register
    jump_e     jump;
    pc_t       target;
  } ctrl_word_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
  } seq_status_t;

  typedef struct packed {
    ctrl_word_t word;
    sec_t       sec;
    logic       in_ready;
    logic       emit;
  } seq_ctrl_t;

  localparam pc_t PC_WAIT = PC_BITS'(0);
  localparam pc_t PC_SECT = PC_BITS'(1);

  // Product of step n is accumulated in step n+1.
  function automatic ctrl_word_t ucode(pc_t pc);
    ctrl_word_t w;
    w = '{COEF_B0, OPND_X, ACC_HOLD, 1'b0, 1'b0, JMP_NEXT, PC_WAIT};
    case (pc)
      4'd0: w.jump = JMP_WAIT_IN;
      4'd1: begin w.coef_sel = COEF_B0; w.opnd_sel = OPND_X; end
      4'd2: begin w.coef_sel = COEF_B1; w.opnd_sel = OPND_XH0; w.acc_op = ACC_LOAD; end
      4'd3: begin w.coef_sel = COEF_B2; w.opnd_sel = OPND_XH1; w.acc_op = ACC_ADD; end
      4'd4: begin w.coef_sel = COEF_A1; w.opnd_sel = OPND_YH0; w.acc_op = ACC_ADD; end
      4'd5: begin w.coef_sel = COEF_A2; w.opnd_sel = OPND_YH1; w.acc_op = ACC_SUB; end
      4'd6: w.acc_op = ACC_SUB;
      4'd7: begin w.finish = 1'b1; w.jump = JMP_MORE_SEC; w.target = PC_SECT; end
      4'd8: begin w.emit = 1'b1; w.jump = JMP_WAIT_OUT; w.target = PC_WAIT; end
      default: begin w.jump = JMP_ALWAYS; w.target = PC_WAIT; end
    endcase
    return w;
  endfunction

endpackage

@@ hdl/bqlc_if.sv @@
// Channel interfaces for the biquad cascade: sample in, sample out, config.
// Depends on bqlc_pkg.
interface bqlc_in_if import bqlc_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface bqlc_out_if import bqlc_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_out;
  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

interface bqlc_cfg_if import bqlc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [COEF_BITS-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ hdl/bqlc_sequencer.sv @@
// Microcode sequencer: step counter, section counter and conditional jumps.
// Depends on bqlc_pkg (ucode table and control types).
module bqlc_sequencer import bqlc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  seq_status_t status_i,
  output seq_ctrl_t   ctrl_o
);

  localparam sec_t LAST_SEC = SEC_BITS'(SECTION_COUNT - 1);

  pc_t        pc_q, pc_d;
  sec_t       sec_q, sec_d;
  ctrl_word_t word;

  always_comb begin
    word  = ucode(pc_q);
    pc_d  = pc_q;
    sec_d = sec_q;
    case (word.jump)
      JMP_NEXT: pc_d = pc_q + PC_BITS'(1);
      JMP_WAIT_IN: begin
        if (status_i.in_valid) begin
          pc_d  = pc_q + PC_BITS'(1);
          sec_d = '0;
        end
      end
      JMP_MORE_SEC: begin
        if (sec_q != LAST_SEC) begin
          pc_d  = word.target;
          sec_d = sec_q + SEC_BITS'(1);
        end else begin
          pc_d = pc_q + PC_BITS'(1);
        end
      end
      JMP_WAIT_OUT: begin
        if (status_i.out_free) pc_d = word.target;
      end
      JMP_ALWAYS: pc_d = word.target;
      default: pc_d = PC_WAIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= PC_WAIT;
      sec_q <= '0;
    end else begin
      pc_q  <= pc_d;
      sec_q <= sec_d;
    end
  end

  assign ctrl_o.word     = word;
  assign ctrl_o.sec      = sec_q;
  assign ctrl_o.in_ready = (word.jump == JMP_WAIT_IN);
  assign ctrl_o.emit     = word.emit & status_i.out_free;

endmodule

@@ hdl/biquad_lowpass_cascade_core.sv @@
// Top level of the two-section direct-form-I biquad low-pass cascade.
// Depends on bqlc_pkg, bqlc_if.sv and bqlc_sequencer.
//
// Usage
//   in_s_i  : one signed Q1.15 sample per transaction (valid/ready).
//   out_s_o : one filtered, saturated Q1.15 sample per input transaction.
//   cfg_i   : coefficient writes, index 0..4 = b0, b1, b2, a1, a2 (Q2.16);
//             other indexes are dropped. Always ready; write only when idle.
//   One shared 18x16 multiplier with a registered product feeds a single
//   accumulator; a 9-step microprogram drives it. Each section runs 5
//   products, one drain and one round/saturate/history step. The sequencer
//   takes one sample at a time: it steps through wait, each section and
//   emit, and returns to wait for the next sample only after the emit step.
//   The output register is separate from the datapath: a new sample is
//   accepted while the last result still waits. If the receiver stalls,
//   the sequencer holds in its emit step until the register frees up.
//   Reset clears all histories, the sequencer and the output valid, and
//   loads the 330 Hz / 8 kHz Butterworth coefficients.
module biquad_lowpass_cascade_core import bqlc_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  bqlc_in_if.sink        in_s_i,
  bqlc_out_if.source     out_s_o,
  bqlc_cfg_if.sink       cfg_i
);

  localparam logic signed [ACC_BITS-1:0] ROUND_HALF =
    ACC_BITS'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_BITS-1:0] SAT_HI =
    ACC_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [ACC_BITS-1:0] SAT_LO =
    -SAT_HI - ACC_BITS'(1);

  // coefficient registers
  coef_t b0_q, b1_q, b2_q, a1_q, a2_q;

  // per-section histories: [0] previous, [1] the one before
  sample_t xh_q [SECTION_COUNT][2];
  sample_t yh_q [SECTION_COUNT][2];

  sample_t                      x_q;     // current section input
  logic signed [PROD_BITS-1:0]  prod_q;
  logic signed [ACC_BITS-1:0]   acc_q;
  logic                         out_valid_q;
  sample_t                      out_q;

  seq_status_t status;
  seq_ctrl_t   ctrl;

  coef_t                       coef_op;
  sample_t                     opnd;
  logic signed [ACC_BITS-1:0]  prod_ext;
  logic signed [ACC_BITS-1:0]  rounded;
  logic signed [ACC_BITS-1:0]  shifted;
  sample_t                     y_sat;
  logic                        accept;

  assign status.in_valid = in_s_i.valid;
  assign status.out_free = ~out_valid_q | out_s_o.ready;

  bqlc_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  assign in_s_i.ready = ctrl.in_ready;
  assign accept       = in_s_i.valid & ctrl.in_ready;
  assign cfg_i.ready  = 1'b1;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_q <= B0_RESET;
      b1_q <= B1_RESET;
      b2_q <= B2_RESET;
      a1_q <= A1_RESET;
      a2_q <= A2_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_B0: b0_q <= cfg_i.data;
        REG_B1: b1_q <= cfg_i.data;
        REG_B2: b2_q <= cfg_i.data;
        REG_A1: a1_q <= cfg_i.data;
        REG_A2: a2_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // multiplier operand selection
  always_comb begin
    case (ctrl.word.coef_sel)
      COEF_B0: coef_op = b0_q;
      COEF_B1: coef_op = b1_q;
      COEF_B2: coef_op = b2_q;
      COEF_A1: coef_op = a1_q;
      COEF_A2: coef_op = a2_q;
      default: coef_op = b0_q;
    endcase
    case (ctrl.word.opnd_sel)
      OPND_X:   opnd = x_q;
      OPND_XH0: opnd = xh_q[ctrl.sec][0];
      OPND_XH1: opnd = xh_q[ctrl.sec][1];
      OPND_YH0: opnd = yh_q[ctrl.sec][0];
      OPND_YH1: opnd = yh_q[ctrl.sec][1];
      default:  opnd = x_q;
    endcase
  end

  // round half up, floor shift, clamp to sample range
  assign prod_ext = ACC_BITS'(prod_q);
  assign rounded  = acc_q + ROUND_HALF;
  assign shifted  = rounded >>> COEF_FRAC_BITS;

  always_comb begin
    if (shifted > SAT_HI) begin
      y_sat = SAT_HI[SAMPLE_BITS-1:0];
    end else if (shifted < SAT_LO) begin
      y_sat = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      y_sat = shifted[SAMPLE_BITS-1:0];
    end
  end

  // datapath payload: product, accumulator, section input
  always_ff @(posedge clk_i) begin
    prod_q <= PROD_BITS'(coef_op * opnd);
    case (ctrl.word.acc_op)
      ACC_LOAD: acc_q <= prod_ext;
      ACC_ADD:  acc_q <= acc_q + prod_ext;
      ACC_SUB:  acc_q <= acc_q - prod_ext;
      default:  acc_q <= acc_q;
    endcase
    if (accept) begin
      x_q <= in_s_i.sample_in;
    end else if (ctrl.word.finish) begin
      x_q <= y_sat;  // feeds next section, or the output on the last
    end
  end

  // filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SECTION_COUNT; s++) begin
        for (int k = 0; k < 2; k++) begin
          xh_q[s][k] <= '0;
          yh_q[s][k] <= '0;
        end
      end
    end else if (ctrl.word.finish) begin
      xh_q[ctrl.sec][1] <= xh_q[ctrl.sec][0];
      xh_q[ctrl.sec][0] <= x_q;
      yh_q[ctrl.sec][1] <= yh_q[ctrl.sec][0];
      yh_q[ctrl.sec][0] <= y_sat;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_s_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit) out_q <= x_q;
  end

  assign out_s_o.valid      = out_valid_q;
  assign out_s_o.sample_out = out_q;

endmodule

@@ dv/bqlc_response_checker.sv @@
`timescale 1ns / 1ps
// Response checker for the biquad low-pass cascade: tracks coefficient writes,
// predicts each filtered sample and scores the output channel. Uses bqlc_pkg.
module bqlc_response_checker import bqlc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  sample_t                 in_sample_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  sample_t                 out_sample_i,
  input  logic                    cfg_valid_i,
  input  logic                    cfg_ready_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [COEF_BITS-1:0]    cfg_data_i,
  output int unsigned             pending_o,
  output int unsigned             fail_o
);

  localparam longint SAMPLE_HI = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SAMPLE_LO = -SAMPLE_HI - 1;
  localparam longint ROUND_HALF = longint'(1) <<< (COEF_FRAC_BITS - 1);

  coef_t   coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
  sample_t x_hist [SECTION_COUNT][2];
  sample_t y_hist [SECTION_COUNT][2];
  sample_t predicted_out_q [$];

  // one direct-form-I section: exact sum, round half up, clamp, shift histories
  function automatic sample_t filter_section(input int unsigned s, input sample_t x);
    longint  acc;
    longint  rounded;
    sample_t y;
    acc = longint'(coef_b0) * longint'(x)
        + longint'(coef_b1) * longint'(x_hist[s][0])
        + longint'(coef_b2) * longint'(x_hist[s][1])
        - longint'(coef_a1) * longint'(y_hist[s][0])
        - longint'(coef_a2) * longint'(y_hist[s][1]);
    rounded = (acc + ROUND_HALF) >>> COEF_FRAC_BITS;
    if (rounded > SAMPLE_HI) y = sample_t'(SAMPLE_HI);
    else if (rounded < SAMPLE_LO) y = sample_t'(SAMPLE_LO);
    else y = sample_t'(rounded);
    x_hist[s][1] = x_hist[s][0];
    x_hist[s][0] = x;
    y_hist[s][1] = y_hist[s][0];
    y_hist[s][0] = y;
    return y;
  endfunction

  function automatic sample_t filter_cascade(input sample_t x);
    sample_t s;
    s = x;
    for (int k = 0; k < SECTION_COUNT; k++) s = filter_section(k, s);
    return s;
  endfunction

  function automatic void apply_coef_write(input logic [CFG_IDX_BITS-1:0] idx,
                                           input logic [COEF_BITS-1:0] value);
    case (cfg_reg_e'(idx))
      REG_B0:  coef_b0 = coef_t'(value);
      REG_B1:  coef_b1 = coef_t'(value);
      REG_B2:  coef_b2 = coef_t'(value);
      REG_A1:  coef_a1 = coef_t'(value);
      REG_A2:  coef_a2 = coef_t'(value);
      default: ;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sample_t want;
    if (!rst_ni) begin
      coef_b0 = B0_RESET;
      coef_b1 = B1_RESET;
      coef_b2 = B2_RESET;
      coef_a1 = A1_RESET;
      coef_a2 = A2_RESET;
      for (int k = 0; k < SECTION_COUNT; k++) begin
        x_hist[k] = '{default: '0};
        y_hist[k] = '{default: '0};
      end
      predicted_out_q.delete();
      pending_o <= 0;
      fail_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) apply_coef_write(cfg_index_i, cfg_data_i);
      // score the output first so a same-edge input cannot satisfy it
      if (out_valid_i && out_ready_i) begin
        if (predicted_out_q.size() == 0) begin
          $error("sample_out: unexpected transaction, expected none, actual %0d",
                 out_sample_i);
          fail_o <= fail_o + 1;
        end else begin
          want = predicted_out_q.pop_front();
          if (out_sample_i !== want) begin
            $error("sample_out: expected %0d, actual %0d", want, out_sample_i);
            fail_o <= fail_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) predicted_out_q.push_back(filter_cascade(in_sample_i));
      pending_o <= predicted_out_q.size();
    end
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// Top of the biquad cascade testbench: clock, reset, sample and coefficient
// stimulus, output back-pressure and verdict. Uses bqlc_pkg, bqlc_if.sv, checker.
module tb_top;
  import bqlc_pkg::*;

  localparam int HALF_PERIOD    = 6;
  localparam int RESET_CYCLES   = 6;
  // longest quiet spell of a correct run is the hold-off plus one sample's
  // processing plus a long sender gap; allow many times that
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_OFF       = 300;
  localparam int DRAIN_CYCLES   = 40;
  localparam int PHASE_COUNT    = 12;
  localparam int PHASE_ITEMS    = 104;
  localparam int HOLD_PHASE     = 4;
  localparam int PAUSE_PHASE    = 5;

  localparam sample_t SAMPLE_MAX_V = sample_t'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam sample_t SAMPLE_MIN_V = sample_t'(-(1 << (SAMPLE_BITS - 1)));
  localparam coef_t   COEF_MAX_V   = coef_t'((1 << (COEF_BITS - 1)) - 1);
  localparam coef_t   COEF_MIN_V   = coef_t'(-(1 << (COEF_BITS - 1)));

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;
  typedef enum int {
    COEFS_RESET, COEFS_GENTLE, COEFS_MAX, COEFS_MIN, COEFS_MIXED, COEFS_FIR, COEFS_RANDOM
  } coef_set_e;

  // coefficient set per phase; each pair of extreme or random sets is followed by a realistic low-pass set
  localparam coef_set_e PHASE_COEFS [PHASE_COUNT] = '{
    COEFS_RESET, COEFS_GENTLE, COEFS_MAX, COEFS_RANDOM, COEFS_GENTLE, COEFS_MIN,
    COEFS_FIR, COEFS_GENTLE, COEFS_RANDOM, COEFS_MIXED, COEFS_GENTLE, COEFS_RESET
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        hold_req;
  idle_mode_e  idle_mode;
  int unsigned pending;
  int unsigned fail_count;
  int unsigned quiet_cycles = 0;
  logic        activity;

  bqlc_in_if  in_if ();
  bqlc_out_if out_if ();
  bqlc_cfg_if cfg_if ();

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  biquad_lowpass_cascade_core u_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_s_i  (in_if),
    .out_s_o (out_if),
    .cfg_i   (cfg_if)
  );

  bqlc_response_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_if.valid),
    .in_ready_i   (in_if.ready),
    .in_sample_i  (in_if.sample_in),
    .out_valid_i  (out_if.valid),
    .out_ready_i  (out_if.ready),
    .out_sample_i (out_if.sample_out),
    .cfg_valid_i  (cfg_if.valid),
    .cfg_ready_i  (cfg_if.ready),
    .cfg_index_i  (cfg_if.index),
    .cfg_data_i   (cfg_if.data),
    .pending_o    (pending),
    .fail_o       (fail_count)
  );

  // Percentage of cycles in which one side idles under the current mode.
  function automatic int unsigned stall_pct(input logic receiver);
    case (idle_mode)
      IDLE_NONE:     return 0;
      IDLE_SENDER:   return receiver ? 0 : 75;
      IDLE_RECEIVER: return receiver ? 75 : 0;
      default:       return 37;
    endcase
  endfunction

  // Watchdog: any transaction on any channel restarts the count.
  assign activity = (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
                    (cfg_if.valid && cfg_if.ready);

  always @(posedge clk) begin
    if (activity) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Output side: random back-pressure, plus one long hold-off on request so
  // the output register and the datapath both fill and input ready drops.
  initial begin : receiver
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
        hold_req = 1'b0;
      end
      out_if.ready <= ($urandom_range(99) >= stall_pct(1'b1));
    end
  end

  // Pending count is settled by the falling edge; resume on a rising one.
  task automatic wait_drained();
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // Offer one sample, after a random gap; valid is left high for a
  // back-to-back follower.
  task automatic send_sample(input sample_t value);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < stall_pct(1'b0)) gap++;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.sample_in <= value;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [COEF_BITS-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  // Writes to the unused indexes go first; the live coefficients of the
  // phase are written after them.
  task automatic load_coefs(input coef_set_e kind);
    coef_t c [5];
    for (int r = int'(REG_A2) + 1; r < (1 << CFG_IDX_BITS); r++) begin
      write_reg(CFG_IDX_BITS'(r), COEF_BITS'($urandom));
    end
    case (kind)
      COEFS_RESET: c = '{B0_RESET, B1_RESET, B2_RESET, A1_RESET, A2_RESET};
      COEFS_MAX:   c = '{default: COEF_MAX_V};
      COEFS_MIN:   c = '{default: COEF_MIN_V};
      COEFS_MIXED: c = '{COEF_MAX_V, COEF_MIN_V, COEF_MAX_V, COEF_MIN_V, COEF_MAX_V};
      COEFS_GENTLE: begin
        // default low-pass nudged about a little: mostly stable, some overshoot
        c[int'(REG_B0)] = coef_t'(int'(B0_RESET) + int'($urandom_range(0, 1023)) - 512);
        c[int'(REG_B1)] = coef_t'(int'(B1_RESET) + int'($urandom_range(0, 1023)) - 512);
        c[int'(REG_B2)] = coef_t'(int'(B2_RESET) + int'($urandom_range(0, 1023)) - 512);
        c[int'(REG_A1)] = coef_t'(int'(A1_RESET) + int'($urandom_range(0, 4095)) - 2048);
        c[int'(REG_A2)] = coef_t'(int'(A2_RESET) + int'($urandom_range(0, 4095)) - 2048);
      end
      COEFS_FIR: begin
        foreach (c[r]) c[r] = coef_t'($urandom);
        c[int'(REG_A1)] = '0;
        c[int'(REG_A2)] = '0;
      end
      default: foreach (c[r]) c[r] = coef_t'($urandom);
    endcase
    for (int r = int'(REG_B0); r <= int'(REG_A2); r++) write_reg(CFG_IDX_BITS'(r), c[r]);
    cfg_if.valid <= 1'b0;
  endtask

  // Sample mix: full range, quiet signal, held steps and rail values.
  function automatic sample_t pick_sample(input sample_t prev);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 50) return sample_t'($urandom);
    if (roll < 70) return sample_t'($urandom_range(0, 511) - 256);
    if (roll < 85) return prev;
    if (roll < 93) return SAMPLE_MAX_V;
    return SAMPLE_MIN_V;
  endfunction

  initial begin : stimulus
    sample_t last;
    in_if.valid      = 1'b0;
    in_if.sample_in  = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = '0;
    cfg_if.data      = '0;
    rst_n            = 1'b0;
    hold_req         = 1'b0;
    idle_mode        = IDLE_NONE;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, on the reset coefficients with no write yet: rail steps
    // drive the low-pass overshoot into saturation, the alternating rails
    // hit the stop-band, then the smallest non-zero values.
    send_sample('0);
    repeat (8) send_sample(SAMPLE_MAX_V);
    repeat (8) send_sample(SAMPLE_MIN_V);
    repeat (2) begin
      send_sample(SAMPLE_MAX_V);
      send_sample(SAMPLE_MIN_V);
    end
    send_sample(sample_t'(1));
    send_sample(sample_t'(-1));
    in_if.valid <= 1'b0;

    // Random part: coefficients only change with the block idle. Histories
    // carry over between phases, as in the block.
    last = '0;
    for (int p = 0; p < PHASE_COUNT; p++) begin
      wait_drained();
      idle_mode = idle_mode_e'(p % 4);
      load_coefs(PHASE_COEFS[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == HOLD_PHASE && n == PHASE_ITEMS / 2) hold_req = 1'b1;
        if (p == PAUSE_PHASE && n == PHASE_ITEMS / 2) begin
          in_if.valid <= 1'b0;
          wait_drained();
        end
        last = pick_sample(last);
        send_sample(last);
      end
      in_if.valid <= 1'b0;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ biquad_lowpass_cascade_core.f @@
hdl/bqlc_pkg.sv
hdl/bqlc_if.sv
hdl/bqlc_sequencer.sv
hdl/biquad_lowpass_cascade_core.sv
dv/bqlc_response_checker.sv
dv/tb_top.sv
